// ===== design/kwc_pkg.sv =====
package kwc_pkg;

  // build defaults
  localparam int unsigned MaxWordDef   = 9;
  localparam int unsigned CountBitsDef = 32;
  localparam int unsigned TagBitsDef   = 16;

  // configuration register
  localparam int unsigned             WordSizeBits  = 4;
  localparam logic [WordSizeBits-1:0] WordSizeReset = 4'd9;

  // base characters
  localparam int unsigned         BaseBits  = 8;
  localparam logic [BaseBits-1:0] CharUpA   = 8'h41;
  localparam logic [BaseBits-1:0] CharLowA  = 8'h61;
  localparam logic [BaseBits-1:0] CharUpG   = 8'h47;
  localparam logic [BaseBits-1:0] CharLowG  = 8'h67;
  localparam logic [BaseBits-1:0] CharUpC   = 8'h43;
  localparam logic [BaseBits-1:0] CharLowC  = 8'h63;
  localparam logic [BaseBits-1:0] CharUpT   = 8'h54;
  localparam logic [BaseBits-1:0] CharLowT  = 8'h74;

  // 2-bit base codes
  localparam logic [1:0] CodeA = 2'h0;
  localparam logic [1:0] CodeG = 2'h1;
  localparam logic [1:0] CodeC = 2'h2;
  localparam logic [1:0] CodeT = 2'h3;

  // depth of the small queues between the parts
  localparam int unsigned QueueDepth = 4;

  // back end sequencing
  typedef enum logic {
    BkClear,
    BkRun
  } back_state_e;

endpackage

// ===== design/kmer_window_counter.sv =====
// Rolling k-mer counter: takes one ASCII base word per cycle while full is low, packs
// it into a 2-bit window (A=0, G=1, C=2, T=3, anything else 0) and, once the window
// holds word_size bases with an A or G in its center, bumps that k-mer's saturating
// count and tags it with the current segment, returning one result word. After reset
// the block sweeps its count/tag memory to zero, one entry per cycle over 4**MAX_WORD
// entries (262144 at the default build) with full held high; word_size writes are
// taken during the sweep. After that it accepts one base per cycle while full is low
// and delivers up to one result per cycle; the rate is set by the read-modify-write of
// the count/tag memory, kept at one access a cycle by forwarding the last write. A
// result passes the request queue, the read and modify stages and the result queue.
// Write word_size only while no work is in flight; a write empties the window.
module kmer_window_counter import kwc_pkg::*; #(
  parameter int unsigned MAX_WORD   = MaxWordDef,
  parameter int unsigned COUNT_BITS = CountBitsDef,
  parameter int unsigned TAG_BITS   = TagBitsDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [WordSizeBits-1:0] cfg_wdata_i,
  input  logic                    push,
  output logic                    full,
  input  logic [BaseBits-1:0]     base_i,
  input  logic                    segment_start_i,
  output logic                    empty,
  input  logic                    pop,
  output logic [2*MAX_WORD-1:0]   word_code_o,
  output logic [COUNT_BITS-1:0]   word_count_o,
  output logic                    new_in_segment_o
);

  localparam int unsigned CodeBits = 2 * MAX_WORD;
  localparam int unsigned ReqBits  = CodeBits + TAG_BITS;
  localparam int unsigned ResBits  = CodeBits + COUNT_BITS + 1;

  logic                  accept;
  logic                  back_busy;
  logic                  req_push, req_full, req_empty, req_pop;
  logic [CodeBits-1:0]   req_kmer, q_kmer;
  logic [TAG_BITS-1:0]   req_tag, q_tag;
  logic                  res_push, res_full, res_fresh;
  logic [CodeBits-1:0]   res_code;
  logic [COUNT_BITS-1:0] res_count;

  // input handshake
  assign full   = back_busy || req_full;
  assign accept = push && !full;

  // front: window and classification
  kwc_front #(
    .MaxWord (MAX_WORD),
    .TagBits (TAG_BITS)
  ) u_front (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_wdata_i,
    .accept_i        (accept),
    .base_i,
    .segment_start_i,
    .req_valid_o     (req_push),
    .req_kmer_o      (req_kmer),
    .req_tag_o       (req_tag)
  );

  // queue between front and back
  kwc_fifo #(
    .Width (ReqBits),
    .Depth (QueueDepth)
  ) u_req_fifo (
    .clk_i,
    .rst_ni,
    .push_i  (req_push),
    .wdata_i ({req_kmer, req_tag}),
    .full_o  (req_full),
    .pop_i   (req_pop),
    .rdata_o ({q_kmer, q_tag}),
    .empty_o (req_empty)
  );

  // back: count and tag update
  kwc_back #(
    .MaxWord   (MAX_WORD),
    .CountBits (COUNT_BITS),
    .TagBits   (TAG_BITS)
  ) u_back (
    .clk_i,
    .rst_ni,
    .req_valid_i (!req_empty),
    .req_kmer_i  (q_kmer),
    .req_tag_i   (q_tag),
    .req_pop_o   (req_pop),
    .busy_o      (back_busy),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_code_o  (res_code),
    .res_count_o (res_count),
    .res_fresh_o (res_fresh)
  );

  // result queue
  kwc_fifo #(
    .Width (ResBits),
    .Depth (QueueDepth)
  ) u_res_fifo (
    .clk_i,
    .rst_ni,
    .push_i  (res_push),
    .wdata_i ({res_code, res_count, res_fresh}),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o ({word_code_o, word_count_o, new_in_segment_o}),
    .empty_o (empty)
  );

  // a delivered count is never zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (word_count_o != '0))
    else $error("result word with zero count");

  // a k-mer already seen in this segment was counted at least once before
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !new_in_segment_o) |-> (word_count_o > COUNT_BITS'(1)))
    else $error("repeat k-mer with count below two");

  // back-to-back updates of one k-mer see the forwarded count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push && $past(res_push) && (res_code == $past(res_code))
      && ($past(res_count) != '1))
      |-> (res_count == COUNT_BITS'($past(res_count) + 1'b1)))
    else $error("lost increment on consecutive update");

endmodule

// ===== design/kwc_fifo.sv =====
module kwc_fifo import kwc_pkg::*; #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PtrBits = (Depth > 1) ? $clog2(Depth) : 1;
  localparam logic [PtrBits-1:0] LastPtr = PtrBits'(Depth - 1);

  logic [Width-1:0]   store_q [Depth];
  logic [PtrBits-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrBits-1:0] rd_ptr_q, rd_ptr_d;
  logic [PtrBits:0]   count_q, count_d;
  logic               do_push, do_pop;

  // handshake qualification
  assign full_o  = (count_q == (PtrBits + 1)'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = store_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // word storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ===== design/kwc_front.sv =====
module kwc_front import kwc_pkg::*; #(
  parameter int unsigned MaxWord = MaxWordDef,
  parameter int unsigned TagBits = TagBitsDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [WordSizeBits-1:0] cfg_wdata_i,
  input  logic                    accept_i,
  input  logic [BaseBits-1:0]     base_i,
  input  logic                    segment_start_i,
  output logic                    req_valid_o,
  output logic [2*MaxWord-1:0]    req_kmer_o,
  output logic [TagBits-1:0]      req_tag_o
);

  localparam int unsigned CodeBits = 2 * MaxWord;
  localparam int unsigned FillBits = $clog2(MaxWord + 1);
  localparam logic [WordSizeBits-1:0] MaxWordW = WordSizeBits'(MaxWord);
  localparam logic [FillBits-1:0]     MaxFill  = FillBits'(MaxWord);

  logic [WordSizeBits-1:0] word_size_q;
  logic [CodeBits-1:0]     window_q, window_d;
  logic [MaxWord-1:0]      purine_q, purine_d, purine_sh;
  logic [FillBits-1:0]     fill_q, fill_d, fill_base, fill_next;
  logic [TagBits-1:0]      seg_q, seg_d, seg_inc, seg_open;
  logic                    start;
  logic [1:0]              code;
  logic                    pur;
  logic [WordSizeBits-1:0] w_sat, w_eff;
  logic [WordSizeBits:0]   w_twice;
  logic [CodeBits-1:0]     kmer_mask;
  logic                    fill_ok;

  // base decode
  always_comb begin
    code = CodeA;
    pur  = 1'b0;
    unique case (base_i) inside
      CharUpA, CharLowA: begin
        code = CodeA;
        pur  = 1'b1;
      end
      CharUpG, CharLowG: begin
        code = CodeG;
        pur  = 1'b1;
      end
      CharUpC, CharLowC: code = CodeC;
      CharUpT, CharLowT: code = CodeT;
      default: begin
        code = CodeA;
        pur  = 1'b0;
      end
    endcase
  end

  // segment open: first base ever also opens one, tag skips zero
  assign start    = segment_start_i || (seg_q == '0);
  assign seg_inc  = seg_q + 1'b1;
  assign seg_open = (seg_inc == '0) ? TagBits'(1) : seg_inc;

  // window shift and fill count
  always_comb begin
    fill_base = start ? '0 : fill_q;
    fill_next = (fill_base < MaxFill) ? FillBits'(fill_base + 1'b1) : fill_base;
    window_d  = CodeBits'({window_q, code});
    purine_d  = MaxWord'({purine_q, pur});
    seg_d     = start ? seg_open : seg_q;
    fill_d    = fill_q;
    if (cfg_we_i) begin
      fill_d = '0;
    end else if (accept_i) begin
      fill_d = fill_next;
    end
  end

  // effective word length: zero as one, clamp to max, even rounded down
  always_comb begin
    w_sat = (word_size_q == '0) ? WordSizeBits'(1) : word_size_q;
    if (w_sat > MaxWordW) begin
      w_sat = MaxWordW;
    end
    w_eff   = w_sat[0] ? w_sat : w_sat - 1'b1;
    w_twice = {w_eff, 1'b0};
  end

  // window full and central base a purine
  assign kmer_mask = ~({CodeBits{1'b1}} << w_twice);
  assign purine_sh = purine_d >> (w_eff >> 1);
  assign fill_ok   = (WordSizeBits'(fill_next) >= w_eff);

  assign req_valid_o = accept_i && fill_ok && purine_sh[0];
  assign req_kmer_o  = window_d & kmer_mask;
  assign req_tag_o   = seg_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_size_q <= WordSizeReset;
      window_q    <= '0;
      purine_q    <= '0;
      fill_q      <= '0;
      seg_q       <= '0;
    end else begin
      fill_q <= fill_d;
      if (cfg_we_i) begin
        word_size_q <= cfg_wdata_i;
      end
      if (accept_i) begin
        window_q <= window_d;
        purine_q <= purine_d;
        seg_q    <= seg_d;
      end
    end
  end

endmodule

// ===== design/kwc_back.sv =====
module kwc_back import kwc_pkg::*; #(
  parameter int unsigned MaxWord   = MaxWordDef,
  parameter int unsigned CountBits = CountBitsDef,
  parameter int unsigned TagBits   = TagBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 req_valid_i,
  input  logic [2*MaxWord-1:0] req_kmer_i,
  input  logic [TagBits-1:0]   req_tag_i,
  output logic                 req_pop_o,
  output logic                 busy_o,
  input  logic                 res_full_i,
  output logic                 res_push_o,
  output logic [2*MaxWord-1:0] res_code_o,
  output logic [CountBits-1:0] res_count_o,
  output logic                 res_fresh_o
);

  localparam int unsigned AddrBits  = 2 * MaxWord;
  localparam int unsigned Depth     = 2 ** AddrBits;
  localparam int unsigned EntryBits = CountBits + TagBits;

  back_state_e state_q, state_d;
  logic [AddrBits-1:0]  clr_addr_q, clr_addr_d;
  logic                 clr_we;

  logic [EntryBits-1:0] store_mem [Depth];
  logic [EntryBits-1:0] rd_data_q;
  logic                 mem_we;
  logic [AddrBits-1:0]  mem_wa;
  logic [EntryBits-1:0] mem_wd;

  logic                 a_fire, b_fire, b_free;
  logic                 b_valid_q, b_valid_d;
  logic [AddrBits-1:0]  b_addr_q;
  logic [TagBits-1:0]   b_tag_q;

  logic                 lw_valid_q;
  logic [AddrBits-1:0]  lw_addr_q;
  logic [EntryBits-1:0] lw_data_q;

  logic [EntryBits-1:0] cur;
  logic [CountBits-1:0] cur_cnt, cnt_new;
  logic [TagBits-1:0]   cur_tag;

  // clearing sweep then normal operation
  always_comb begin
    state_d    = state_q;
    clr_addr_d = clr_addr_q;
    unique case (state_q)
      BkClear: begin
        clr_addr_d = clr_addr_q + 1'b1;
        if (clr_addr_q == '1) begin
          state_d = BkRun;
        end
      end
      BkRun: state_d = BkRun;
      default: state_d = BkClear;
    endcase
  end

  always_comb begin
    busy_o = 1'b0;
    clr_we = 1'b0;
    unique case (state_q)
      BkClear: begin
        busy_o = 1'b1;
        clr_we = 1'b1;
      end
      BkRun: begin
        busy_o = 1'b0;
        clr_we = 1'b0;
      end
      default: begin
        busy_o = 1'b1;
        clr_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= BkClear;
      clr_addr_q <= '0;
    end else begin
      state_q    <= state_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  // read stage issues when the modify stage frees up
  assign b_fire    = b_valid_q && !res_full_i;
  assign b_free    = !b_valid_q || b_fire;
  assign a_fire    = (state_q == BkRun) && req_valid_i && b_free;
  assign req_pop_o = a_fire;
  assign b_valid_d = a_fire ? 1'b1 : (b_fire ? 1'b0 : b_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q  <= 1'b0;
      lw_valid_q <= 1'b0;
    end else begin
      b_valid_q <= b_valid_d;
      if (b_fire) begin
        lw_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_fire) begin
      b_addr_q <= req_kmer_i;
      b_tag_q  <= req_tag_i;
    end
    if (b_fire) begin
      lw_addr_q <= b_addr_q;
      lw_data_q <= mem_wd;
    end
  end

  // modify stage, forwarding the write that raced the read
  always_comb begin
    cur     = (lw_valid_q && (lw_addr_q == b_addr_q)) ? lw_data_q : rd_data_q;
    cur_cnt = cur[EntryBits-1:TagBits];
    cur_tag = cur[TagBits-1:0];
    cnt_new = (cur_cnt == '1) ? cur_cnt : CountBits'(cur_cnt + 1'b1);
  end

  assign res_push_o  = b_fire;
  assign res_code_o  = b_addr_q;
  assign res_count_o = cnt_new;
  assign res_fresh_o = (cur_tag != b_tag_q);

  // count and tag store
  assign mem_we = clr_we || b_fire;
  assign mem_wa = clr_we ? clr_addr_q : b_addr_q;
  assign mem_wd = clr_we ? '0 : {cnt_new, b_tag_q};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_mem[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_fire) begin
      rd_data_q <= store_mem[req_kmer_i];
    end
  end

endmodule
